### design/pcs_pkg.sv
// Package: payload types, controller states and command/status structs for the correlation block.
package pcs_pkg;

  localparam int unsigned QUO_BITS  = 29;  // floor(num^2 * 2^28 / den) <= 2^28
  localparam int unsigned ROOT_BITS = 15;  // sqrt of that <= 16384
  localparam int unsigned FRAC_BITS = 28;

  typedef struct packed {
    logic signed [15:0] actual_value;
    logic signed [15:0] predicted_value;
    logic               last_pair;
  } in_t;

  typedef struct packed {
    logic signed [15:0] correlation;
    logic               result_valid;
    logic [16:0]        pair_count;
  } out_t;

  typedef enum logic [2:0] {
    S_ACC,
    S_LOAD,
    S_MUL,
    S_MST,
    S_DIV,
    S_SQRT,
    S_OUT
  } state_e;

  // product being formed by the shared serial multiplier
  typedef enum logic [2:0] {
    PH_P,    // n * Sxy
    PH_Q,    // Sx * Sy
    PH_A1,   // n * Sxx
    PH_B1,   // Sx^2
    PH_A2,   // n * Syy
    PH_B2,   // Sy^2
    PH_DEN,  // va * vb
    PH_NSQ   // num^2
  } phase_e;

  typedef struct packed {
    logic       acc_en;
    logic       clear;
    logic       mul_load;
    logic       mul_step;
    logic       mul_store;
    phase_e     phase;
    logic       div_init;
    logic       div_step;
    logic       sqrt_step;
    logic [3:0] sqrt_bit;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic var_ok;
  } sts_t;

endpackage

### design/pcs_datapath.sv
// Datapath: accumulators, serial multiplier, restoring divider and bitwise square root.
module pcs_datapath #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_PAIRS   = 65536
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcs_pkg::in_t  in_i,
  input  pcs_pkg::cmd_t cmd_i,
  output pcs_pkg::sts_t sts_o,
  output pcs_pkg::out_t out_o
);

  localparam int unsigned CW = $clog2(MAX_PAIRS + 1);
  localparam int unsigned AW = 2 * SAMPLE_BITS + CW;
  localparam int unsigned OW = 2 * SAMPLE_BITS + 2 * CW + 2;
  localparam int unsigned PW = 2 * OW;
  localparam int unsigned XW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

  function automatic logic [OW-1:0] mag(input logic signed [AW-1:0] v);
    logic signed [AW:0] e;
    e = (AW + 1)'(v);
    if (e < 0) e = -e;
    return OW'(unsigned'(e));
  endfunction

  // sample extraction: low SAMPLE_BITS of the zero-extended field, as two's complement
  logic [XW-1:0]                 xz, yz;
  logic signed [SAMPLE_BITS-1:0] xs, ys;
  logic signed [2*SAMPLE_BITS-1:0] pxy, pxx, pyy;
  assign xz  = XW'(unsigned'(in_i.actual_value));
  assign yz  = XW'(unsigned'(in_i.predicted_value));
  assign xs  = signed'(xz[SAMPLE_BITS-1:0]);
  assign ys  = signed'(yz[SAMPLE_BITS-1:0]);
  assign pxy = xs * ys;
  assign pxx = xs * xs;
  assign pyy = ys * ys;

  logic [CW-1:0]        n_q;
  logic signed [AW-1:0] sx_q, sy_q, sxy_q, sxx_q, syy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
      syy_q <= '0;
    end else if (cmd_i.clear) begin
      n_q   <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxy_q <= '0;
      sxx_q <= '0;
      syy_q <= '0;
    end else if (cmd_i.acc_en && (n_q < CW'(MAX_PAIRS))) begin
      n_q   <= n_q + 1'b1;
      sx_q  <= sx_q + AW'(xs);
      sy_q  <= sy_q + AW'(ys);
      sxy_q <= sxy_q + AW'(pxy);
      sxx_q <= sxx_q + AW'(pxx);
      syy_q <= syy_q + AW'(pyy);
    end
  end

  // shared shift-add multiplier, one multiplier bit per cycle
  logic [PW-1:0] mc_q, prod_q;
  logic [OW-1:0] mp_q;
  logic          sgn_q;
  logic [OW-1:0] op_a, op_b;
  logic          op_sgn;

  logic signed [PW+1:0] t1_q, num_q, psg;
  logic [OW-1:0]        va_q, vb_q, num_mag;
  logic [PW-1:0]        den_q;
  logic                 neg_q;

  assign num_mag = OW'(unsigned'((num_q < 0) ? -num_q : num_q));

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sgn = 1'b0;
    unique case (cmd_i.phase)
      pcs_pkg::PH_P: begin
        op_a   = OW'(n_q);
        op_b   = mag(sxy_q);
        op_sgn = sxy_q < 0;
      end
      pcs_pkg::PH_Q: begin
        op_a   = mag(sx_q);
        op_b   = mag(sy_q);
        op_sgn = (sx_q < 0) != (sy_q < 0);
      end
      pcs_pkg::PH_A1: begin
        op_a = OW'(n_q);
        op_b = mag(sxx_q);
      end
      pcs_pkg::PH_B1: begin
        op_a = mag(sx_q);
        op_b = mag(sx_q);
      end
      pcs_pkg::PH_A2: begin
        op_a = OW'(n_q);
        op_b = mag(syy_q);
      end
      pcs_pkg::PH_B2: begin
        op_a = mag(sy_q);
        op_b = mag(sy_q);
      end
      pcs_pkg::PH_DEN: begin
        op_a = va_q;
        op_b = vb_q;
      end
      pcs_pkg::PH_NSQ: begin
        op_a = num_mag;
        op_b = num_mag;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_load) begin
      prod_q <= '0;
      mc_q   <= PW'(op_a);
      mp_q   <= op_b;
      sgn_q  <= op_sgn;
    end else if (cmd_i.mul_step) begin
      if (mp_q[0]) prod_q <= prod_q + mc_q;
      mc_q <= mc_q << 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign psg = signed'({2'b00, prod_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_store) begin
      unique case (cmd_i.phase)
        pcs_pkg::PH_P:   t1_q <= sgn_q ? -psg : psg;
        pcs_pkg::PH_Q:   num_q <= t1_q - (sgn_q ? -psg : psg);
        pcs_pkg::PH_A1,
        pcs_pkg::PH_A2:  t1_q <= psg;
        pcs_pkg::PH_B1:  va_q <= (t1_q > psg) ? OW'(unsigned'(t1_q - psg)) : '0;
        pcs_pkg::PH_B2:  vb_q <= (t1_q > psg) ? OW'(unsigned'(t1_q - psg)) : '0;
        pcs_pkg::PH_DEN: den_q <= prod_q;
        pcs_pkg::PH_NSQ: neg_q <= num_q < 0;
        default: ;
      endcase
    end
  end

  assign sts_o.var_ok = (va_q != '0) && (vb_q != '0);

  // restoring division: num^2 <= den, so the quotient has one integer bit
  logic [PW:0]                     rem_q, rem_sub;
  logic                            qbit;
  logic [pcs_pkg::QUO_BITS-1:0]    quo_q;
  logic [pcs_pkg::ROOT_BITS-1:0]   root_q, trial;
  logic [2*pcs_pkg::ROOT_BITS-1:0] trial_sq;

  assign qbit    = rem_q >= {1'b0, den_q};
  assign rem_sub = qbit ? (rem_q - {1'b0, den_q}) : rem_q;
  assign trial   = root_q | (pcs_pkg::ROOT_BITS'(1) << cmd_i.sqrt_bit);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q  <= {1'b0, prod_q};
      quo_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_sub << 1;
      quo_q <= {quo_q[pcs_pkg::QUO_BITS-2:0], qbit};
    end else if (cmd_i.sqrt_step) begin
      if ((2*pcs_pkg::ROOT_BITS)'(trial_sq) <= (2*pcs_pkg::ROOT_BITS)'(quo_q)) root_q <= trial;
    end
  end

  logic signed [15:0] corr;
  always_comb begin
    corr = '0;
    if (sts_o.var_ok) corr = neg_q ? -signed'(16'(root_q)) : signed'(16'(root_q));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_o.correlation  <= corr;
      out_o.result_valid <= sts_o.var_ok;
      out_o.pair_count   <= 17'(n_q);
    end
  end

endmodule

### design/pcs_ctrl.sv
// Controller: sequences accumulation, the eight products, division and square root.
module pcs_ctrl #(
  parameter int unsigned MUL_STEPS = 68
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pcs_pkg::sts_t sts_i,
  output pcs_pkg::cmd_t cmd_o
);

  localparam int unsigned NW = $clog2(MUL_STEPS + 1);

  pcs_pkg::state_e state_q, state_d;
  pcs_pkg::phase_e phase_q, phase_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic            ov_q, ov_d;
  logic            out_free;

  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      pcs_pkg::S_ACC: begin
        if (in_valid_i && in_last_i) begin
          state_d = pcs_pkg::S_LOAD;
          phase_d = pcs_pkg::PH_P;
        end
      end
      pcs_pkg::S_LOAD: begin
        state_d = pcs_pkg::S_MUL;
        cnt_d   = NW'(MUL_STEPS - 1);
      end
      pcs_pkg::S_MUL: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = pcs_pkg::S_MST;
      end
      pcs_pkg::S_MST: begin
        state_d = pcs_pkg::S_LOAD;
        unique case (phase_q)
          pcs_pkg::PH_P:   phase_d = pcs_pkg::PH_Q;
          pcs_pkg::PH_Q:   phase_d = pcs_pkg::PH_A1;
          pcs_pkg::PH_A1:  phase_d = pcs_pkg::PH_B1;
          pcs_pkg::PH_B1:  phase_d = pcs_pkg::PH_A2;
          pcs_pkg::PH_A2:  phase_d = pcs_pkg::PH_B2;
          pcs_pkg::PH_B2:  phase_d = pcs_pkg::PH_DEN;
          pcs_pkg::PH_DEN: phase_d = pcs_pkg::PH_NSQ;
          pcs_pkg::PH_NSQ: begin
            state_d = sts_i.var_ok ? pcs_pkg::S_DIV : pcs_pkg::S_OUT;
            cnt_d   = NW'(pcs_pkg::QUO_BITS - 1);
          end
          default: ;
        endcase
      end
      pcs_pkg::S_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = pcs_pkg::S_SQRT;
          cnt_d   = NW'(pcs_pkg::ROOT_BITS - 1);
        end
      end
      pcs_pkg::S_SQRT: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = pcs_pkg::S_OUT;
      end
      pcs_pkg::S_OUT: begin
        if (out_free) state_d = pcs_pkg::S_ACC;
      end
      default: state_d = pcs_pkg::S_ACC;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.phase     = phase_q;
    cmd_o.sqrt_bit  = 4'(cnt_q);
    in_ready_o      = 1'b0;
    ov_d            = ov_q && !out_ready_i;
    unique case (state_q)
      pcs_pkg::S_ACC: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_valid_i;
      end
      pcs_pkg::S_LOAD: cmd_o.mul_load = 1'b1;
      pcs_pkg::S_MUL:  cmd_o.mul_step = 1'b1;
      pcs_pkg::S_MST: begin
        cmd_o.mul_store = 1'b1;
        cmd_o.div_init  = phase_q == pcs_pkg::PH_NSQ;
      end
      pcs_pkg::S_DIV:  cmd_o.div_step = 1'b1;
      pcs_pkg::S_SQRT: cmd_o.sqrt_step = 1'b1;
      pcs_pkg::S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = 1'b1;
          ov_d           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcs_pkg::S_ACC;
      phase_q <= pcs_pkg::PH_P;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule

### design/pearson_correlation_stream.sv
// Top level: streaming Pearson correlation over request pairs, result in Q1.14.
//
//   channel | dir | handshake                 | payload
//   input   | in  | in_valid_i / in_ready_o   | in_i  (actual, predicted, last_pair)
//   output  | out | out_valid_o / out_ready_i | out_o (correlation, result_valid, pair_count)
//
// One request per cycle while accumulating. After a request marked last, eight
// serial products of OW-bit operands (OW = 2*SAMPLE_BITS + 2*clog2(MAX_PAIRS+1) + 2),
// a 29-step division and a 15-step square root run (both skipped when a variance is
// zero); requests are held off meanwhile. The result then waits in the output
// register; the next data set accumulates while it is pending. Reset clears all sums.
module pearson_correlation_stream #(
  parameter int unsigned MAX_PAIRS   = 65536,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pcs_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pcs_pkg::out_t out_o
);

  localparam int unsigned CW = $clog2(MAX_PAIRS + 1);
  localparam int unsigned OW = 2 * SAMPLE_BITS + 2 * CW + 2;

  pcs_pkg::cmd_t cmd;
  pcs_pkg::sts_t sts;

  pcs_ctrl #(
    .MUL_STEPS(OW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_i.last_pair),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcs_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_PAIRS  (MAX_PAIRS)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .out_o (out_o)
  );

endmodule

### tb/tb_pearson_correlation_stream.sv
// Testbench for pearson_correlation_stream: directed and random data sets scored against a bit-exact predictor.
module tb_pearson_correlation_stream;

  localparam int unsigned MAX_PAIRS  = 65536;
  localparam int unsigned CYCLE_CAP  = 1500000;
  localparam int unsigned SOLVE_WAIT = 700;  // longer than the post-set arithmetic

  typedef enum int {
    MIX_RANDOM, MIX_TRACK, MIX_MIRROR, MIX_FLAT_X, MIX_FLAT_Y, MIX_TINY, MIX_EDGE
  } mix_e;

  class corr_scoreboard;
    logic [16:0]        n;
    logic signed [32:0] sx, sy;
    logic signed [47:0] sxy;
    logic [46:0]        sxx, syy;
    pcs_pkg::out_t      awaiting[$];
    int                 mismatches, results, undefined, saturated;

    function new();
      clear_sums();
      mismatches = 0;
      results    = 0;
      undefined  = 0;
      saturated  = 0;
    endfunction

    function void clear_sums();
      n   = '0;
      sx  = '0;
      sy  = '0;
      sxy = '0;
      sxx = '0;
      syy = '0;
    endfunction

    // folds one accepted request into the sums; a last pair yields a result
    function void note_pair(pcs_pkg::in_t p);
      longint              a, b;
      logic signed [131:0] nn, num, va, vb, mag;
      logic [263:0]        den, rhs, lhs;
      int unsigned         lo, hi, mid;
      pcs_pkg::out_t       r;
      a = longint'(p.actual_value);
      b = longint'(p.predicted_value);
      if (n < MAX_PAIRS) begin
        sx  = sx + 33'(a);
        sy  = sy + 33'(b);
        sxy = sxy + 48'(a * b);
        sxx = sxx + 47'(a * a);
        syy = syy + 47'(b * b);
        n   = n + 17'd1;
      end else begin
        saturated++;
      end
      if (!p.last_pair) return;
      nn  = 132'(n);
      num = nn * sxy - sx * sy;
      va  = nn * $signed({1'b0, sxx}) - sx * sx;
      vb  = nn * $signed({1'b0, syy}) - sy * sy;
      r.pair_count   = n;
      r.result_valid = (va > 0) && (vb > 0);
      r.correlation  = '0;
      if (r.result_valid) begin
        mag = (num < 0) ? -num : num;
        den = 264'(va[131:0]);
        den = den * 264'(vb[131:0]);
        rhs = 264'(mag[131:0]);
        rhs = (rhs * rhs) << pcs_pkg::FRAC_BITS;
        lo  = 0;
        hi  = 16384;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          lhs = 264'(mid);
          lhs = lhs * lhs;
          lhs = lhs * den;
          if (lhs <= rhs) lo = mid;
          else hi = mid - 1;
        end
        r.correlation = (num < 0) ? -16'(lo) : 16'(lo);
      end else begin
        undefined++;
      end
      awaiting = {awaiting, r};
      clear_sums();
    endfunction

    function void check_result(pcs_pkg::out_t got);
      pcs_pkg::out_t want;
      if (awaiting.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: corr=%0d valid=%0d count=%0d",
                   got.correlation, got.result_valid, got.pair_count);
        return;
      end
      want = awaiting.pop_front();
      results++;
      if (got.correlation !== want.correlation || got.result_valid !== want.result_valid ||
          got.pair_count !== want.pair_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected corr=%0d valid=%0d count=%0d, got corr=%0d valid=%0d count=%0d",
                   want.correlation, want.result_valid, want.pair_count,
                   got.correlation, got.result_valid, got.pair_count);
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  pcs_pkg::in_t  in_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  pcs_pkg::out_t out_o;

  corr_scoreboard sb = new();
  int unsigned    cycles = 0;
  int unsigned    hold_off = 0;  // receiver stall requested by the stimulus
  bit             no_gaps = 1'b0;
  int unsigned    sets_sent = 0;

  always #4 clk_i = ~clk_i;

  pearson_correlation_stream dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i, .out_valid_o, .out_ready_i, .out_o
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_o);
  end

  // receiver: random stalls, plus one long hold when asked
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_ready_i = 1'b0;
      hold_off    = hold_off - 1;
    end else begin
      out_ready_i = no_gaps || ($urandom_range(99) >= 8);
    end
  end

  task automatic send_pair(input pcs_pkg::in_t p);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < 8) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_i       = p;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pair(p);
  endtask

  function automatic logic signed [15:0] edge_val();
    case ($urandom_range(3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  task automatic send_set(input int unsigned len, input mix_e mix);
    pcs_pkg::in_t       p;
    logic signed [15:0] fx, fy;
    fx = 16'($urandom);
    fy = 16'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      p.actual_value    = 16'($urandom);
      p.predicted_value = 16'($urandom);
      case (mix)
        MIX_TRACK:  p.predicted_value = p.actual_value + 16'($signed($urandom_range(64)) - 32);
        MIX_MIRROR: p.predicted_value = -p.actual_value;
        MIX_FLAT_X: p.actual_value = fx;
        MIX_FLAT_Y: p.predicted_value = fy;
        MIX_TINY: begin
          p.actual_value    = 16'($signed($urandom_range(6)) - 3);
          p.predicted_value = 16'($signed($urandom_range(6)) - 3);
        end
        MIX_EDGE: begin
          p.actual_value    = edge_val();
          p.predicted_value = edge_val();
        end
        default: ;
      endcase
      p.last_pair = (i == len - 1);
      send_pair(p);
    end
    sets_sent++;
  endtask

  task automatic send_fixed(input logic signed [15:0] a, input logic signed [15:0] b,
                            input logic last);
    pcs_pkg::in_t p;
    p.actual_value    = a;
    p.predicted_value = b;
    p.last_pair       = last;
    send_pair(p);
  endtask

  initial begin
    mix_e m;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: lone pair, opposite extremes, exact +1, flat inputs, a small three-pair set, edge values
    send_fixed(16'sh7fff, 16'sh8000, 1'b1);
    send_fixed(16'sh8000, 16'sh7fff, 1'b0);
    send_fixed(16'sh7fff, 16'sh8000, 1'b1);
    send_fixed(16'sh8000, 16'sh8000, 1'b0);
    send_fixed(16'sh7fff, 16'sh7fff, 1'b0);
    send_fixed(16'sh0000, 16'sh0000, 1'b1);
    send_fixed(16'sh1234, 16'sh0001, 1'b0);
    send_fixed(16'sh1234, 16'shffff, 1'b0);
    send_fixed(16'sh1234, 16'sh4000, 1'b1);
    send_fixed(16'sh0010, 16'sh5555, 1'b0);
    send_fixed(16'shfff0, 16'sh5555, 1'b1);
    send_fixed(16'sh0001, 16'sh0003, 1'b0);
    send_fixed(16'sh0002, 16'sh0001, 1'b0);
    send_fixed(16'sh0003, 16'sh0002, 1'b1);
    send_set(4, MIX_EDGE);

    for (int unsigned k = 0; k < 120; k++) begin
      // a stretch without gaps on either side
      no_gaps = (k >= 40 && k < 55);
      if (k == 70) hold_off = 3000;  // block fills and stalls its input
      m = mix_e'($urandom_range(MIX_EDGE));
      if ($urandom_range(3) != 0) m = ($urandom_range(1) != 0) ? MIX_RANDOM : MIX_TRACK;
      send_set(($urandom_range(9) == 0) ? 1 + $urandom_range(1) : 2 + $urandom_range(10), m);
    end
    no_gaps = 1'b0;
    @(negedge clk_i);
    in_valid_i = 1'b0;

    while (sb.awaiting.size() != 0) @(posedge clk_i);
    repeat (SOLVE_WAIT) @(posedge clk_i);

    $display("data sets: %0d, results checked: %0d (%0d with zero variance)",
             sets_sent, sb.results, sb.undefined);
    $display("pairs dropped at the count limit: %0d, mismatches: %0d",
             sb.saturated, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaiting.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/pcs_pkg.sv
design/pcs_datapath.sv
design/pcs_ctrl.sv
design/pearson_correlation_stream.sv
tb/tb_pearson_correlation_stream.sv
